/* sv/wrs_pkg.sv */
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants for the water ripple stencil step.
// ----------------------------------------------------------------------------
package wrs_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 1024;

	localparam int SAMPLE_W = 16;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W  = 8;
	localparam int HEIGHT_W = 11;
	localparam int SHIFT_W  = 4;

	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_DAMPING_SHIFT = 2'd2;

	localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH   = 8'd120;
	localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT  = 11'd67;
	localparam logic [SHIFT_W-1:0]  RST_DAMPING_SHIFT = 4'd5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one line-store entry: row r-2 prev, row r-1 prev, row r-1 older
	typedef struct packed {
		sample_t above;
		sample_t middle;
		sample_t older;
	} line_word_t;

	localparam int LINE_W = $bits(line_word_t);

	// clamped configuration
	typedef struct packed {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic [SHIFT_W-1:0]  shift;
	} cfg_t;

	// one accepted pixel that emits results
	typedef struct packed {
		sample_t          sample;  // t for interior, older value for border
		logic             damp;    // apply damping to sample
		sample_t          older;   // second result value on last row
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;     // row of first result
		logic             two;     // last row: second result follows
	} emit_item_t;

	typedef struct packed {
		logic s1_free;
		logic pend_second;
	} emit_status_t;

endpackage

/* sv/water_ripple_stencil_step.sv */
// ----------------------------------------------------------------------------
// water_ripple_stencil_step
// One time step of a two-buffer ripple field, streamed in raster order.
// ----------------------------------------------------------------------------
// Each input word carries the previous-frame and older-frame sample of one
// pixel; results leave one row late, so the word for pixel (c, r) returns
// pixel (c, r-1), and a word of the last row also returns its own pixel
// (border, older value passed through), with tlast set only on that second
// word of the pair and on every word outside such a pair. Row 0 words
// return nothing. Interior pixels get t = (up + down + left + right) >>> 1
// - older, then t - (t >>> damping_shift), all wrapped to 16 bits; border
// pixels pass the older sample through. Rate: one input word per clock in
// steady state while m_tready is high, limited by the single output
// register: on the last row each input makes two output words, so there an
// input is taken only as the second word of the one before moves on. The
// first result word passes the result stage and then the output register.
// The line store is one 128 x 48 RAM (one write, one read port); every
// accept writes column c and reads column c+2 ahead, so entries c and c+1
// are always on hand. After reset and every register write the block
// refetches that lookahead in FILL0 and FILL1, with s_tready low. Registers:
// 0x0 frame_width (3..128), 0x4 frame_height (3..1024), 0x8 damping_shift;
// out-of-range sizes are clamped. Write the registers only between frames.
// ----------------------------------------------------------------------------
module water_ripple_stencil_step import wrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] prev_sample, [31:16] older_sample
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] new_sample, [22:16] out_col,
	                                         // [32:23] out_row, [39:33] zero
	output logic                  m_tlast    // last_of_run
);

	localparam logic [1:0] ST_FILL0 = 2'd0;  // read entry c
	localparam logic [1:0] ST_FILL1 = 2'd1;  // latch entry c, read entry c+1
	localparam logic [1:0] ST_RUN   = 2'd2;

	cfg_t         cfg;
	logic         cfg_wr;
	emit_status_t emit_st;
	emit_item_t   item;

	logic [1:0]       state_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	line_word_t       cur_q;    // line-store entry of the current column
	sample_t          left_q;   // row r-1 prev sample of column c-1
	line_word_t       nxt;      // entry of column c+1, straight from RAM

	logic               acc;
	logic [COL_W-1:0]   c_eff;
	logic [ROW_W-1:0]   r_eff;
	logic [WIDTH_W-1:0] c_ext;
	logic [WIDTH_W-1:0] c1;
	logic [WIDTH_W-1:0] c2;
	logic [COL_W-1:0]   c1_wrap;
	logic [COL_W-1:0]   c2_wrap;
	logic [ROW_W:0]     r1;
	sample_t            prev_in;
	sample_t            older_in;
	logic [17:0]        sum;
	sample_t            t_val;
	logic               border;

	logic               ram_we;
	logic               ram_re;
	logic [COL_W-1:0]   ram_waddr;
	logic [COL_W-1:0]   ram_raddr;
	logic [LINE_W-1:0]  ram_rdata;
	line_word_t         ram_wdata;

	wrs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	wrs_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (LINE_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign nxt      = line_word_t'(ram_rdata);
	assign prev_in  = s_tdata[15:0];
	assign older_in = s_tdata[31:16];

	// counters left out of range by a size change restart at zero
	assign c_eff = ({1'b0, col_q} >= cfg.width) ? '0 : col_q;
	assign r_eff = ({1'b0, row_q} >= cfg.height) ? '0 : row_q;

	assign c_ext   = {1'b0, c_eff};
	assign c1      = c_ext + WIDTH_W'(1);
	assign c2      = c_ext + WIDTH_W'(2);
	assign c1_wrap = (c1 >= cfg.width) ? '0 : c1[COL_W-1:0];
	assign c2_wrap = (c2 >= cfg.width) ? COL_W'(c2 - cfg.width) : c2[COL_W-1:0];
	assign r1      = {1'b0, r_eff} + (ROW_W+1)'(1);

	assign s_tready = (state_q == ST_RUN) && emit_st.s1_free;
	assign acc      = s_tvalid && s_tready;

	// line-store port use
	assign ram_we    = acc;
	assign ram_waddr = c_eff;
	assign ram_wdata = '{above: cur_q.middle, middle: prev_in, older: older_in};

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = c_eff;
		case (state_q)
			ST_FILL0: begin
				ram_re = 1'b1;
			end
			ST_FILL1: begin
				ram_re    = 1'b1;
				ram_raddr = c1_wrap;
			end
			ST_RUN: begin
				ram_re    = acc;
				ram_raddr = c2_wrap;
			end
			default: ;
		endcase
	end

	// stencil: four neighbors, halve, subtract older
	assign sum = {{2{left_q[15]}}, left_q} + {{2{nxt.middle[15]}}, nxt.middle}
	           + {{2{cur_q.above[15]}}, cur_q.above} + {{2{prev_in[15]}}, prev_in};
	assign t_val  = sum[16:1] - cur_q.older;
	assign border = (r_eff == ROW_W'(1)) || (c_eff == '0)
	              || (c_ext == cfg.width - WIDTH_W'(1));

	assign item.sample = border ? cur_q.older : t_val;
	assign item.damp   = !border;
	assign item.older  = older_in;
	assign item.col    = c_eff;
	assign item.row    = r_eff - ROW_W'(1);
	assign item.two    = ({1'b0, r_eff} == cfg.height - HEIGHT_W'(1));

	wrs_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (acc && (r_eff != '0)),
		.item     (item),
		.shift    (cfg.shift),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.status   (emit_st)
	);

	// lookahead fill sequencer and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cfg_wr) begin
				state_q <= ST_FILL0;
			end else begin
				case (state_q)
					ST_FILL0: state_q <= ST_FILL1;
					ST_FILL1: state_q <= ST_RUN;
					ST_RUN:   state_q <= ST_RUN;
					default:  state_q <= ST_FILL0;
				endcase
			end
			if (acc) begin
				if (c1 >= cfg.width) begin
					col_q <= '0;
					row_q <= (r1 >= cfg.height) ? '0 : r1[ROW_W-1:0];
				end else begin
					col_q <= c1[COL_W-1:0];
					row_q <= r_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FILL1) || acc) begin
			cur_q <= nxt;
		end
		if (acc) begin
			left_q <= cur_q.middle;
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// the write of column c never collides with the lookahead read
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("line store read and write hit the same entry");

	// after an accept the column counter stays inside the frame
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !cfg_wr |=> {1'b0, col_q} < cfg.width)
		else $error("column counter ran past the frame width");

	// a word without tlast always has its partner waiting in the result stage
	a_second_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> emit_st.pend_second)
		else $error("first of two words shown without its second pending");

endmodule

/* sv/wrs_line_ram.sv */
// ----------------------------------------------------------------------------
// wrs_line_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wrs_line_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/wrs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// wrs_cfg_regs
// APB register file: frame width, frame height, damping shift.
// ----------------------------------------------------------------------------
module wrs_cfg_regs import wrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg,
	output logic               cfg_wr
);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic [1:0]          idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_FRAME_WIDTH;
			height_q <= RST_FRAME_HEIGHT;
			shift_q  <= RST_DAMPING_SHIFT;
		end else if (cfg_wr) begin
			case (idx)
				REG_FRAME_WIDTH:   width_q  <= pwdata[WIDTH_W-1:0];
				REG_FRAME_HEIGHT:  height_q <= pwdata[HEIGHT_W-1:0];
				REG_DAMPING_SHIFT: shift_q  <= pwdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:   prdata = {{(PDATA_W-WIDTH_W){1'b0}}, width_q};
			REG_FRAME_HEIGHT:  prdata = {{(PDATA_W-HEIGHT_W){1'b0}}, height_q};
			REG_DAMPING_SHIFT: prdata = {{(PDATA_W-SHIFT_W){1'b0}}, shift_q};
			default:           prdata = '0;
		endcase
	end

	// clamp to the supported frame size
	always_comb begin
		if (width_q < WIDTH_W'(3)) begin
			cfg.width = WIDTH_W'(3);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			cfg.width = WIDTH_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q < HEIGHT_W'(3)) begin
			cfg.height = HEIGHT_W'(3);
		end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			cfg.height = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		cfg.shift = shift_q;
	end

endmodule

/* sv/wrs_emit.sv */
// ----------------------------------------------------------------------------
// wrs_emit
// Result stage: damping, second result on the last row, output register.
// ----------------------------------------------------------------------------
module wrs_emit import wrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ld,
	input  emit_item_t            item,
	input  logic [SHIFT_W-1:0]    shift,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	output emit_status_t          status
);

	emit_item_t       item_s1;
	logic             valid_s1;
	logic             phase_q;
	sample_t          sample_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_q;
	logic             adv;
	logic             done;
	sample_t          damped;

	assign adv  = valid_s1 && (!m_tvalid || m_tready);
	assign done = adv && (phase_q || !item_s1.two);

	assign status.s1_free     = !valid_s1 || done;
	assign status.pend_second = valid_s1 && phase_q;

	// t - (t >>> shift), wrapped
	assign damped = item_s1.sample - (item_s1.sample >>> shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (ld) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				phase_q <= !done;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			item_s1 <= item;
		end
		if (adv) begin
			if (phase_q) begin
				sample_q <= item_s1.older;
				row_q    <= item_s1.row + ROW_W'(1);
			end else begin
				sample_q <= item_s1.damp ? damped : item_s1.sample;
				row_q    <= item_s1.row;
			end
			col_q  <= item_s1.col;
			last_q <= phase_q || !item_s1.two;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-SAMPLE_W-COL_W-ROW_W){1'b0}}, row_q, col_q, sample_q};
	assign m_tlast = last_q;

endmodule
